>>> hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the single-wire pulse width transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    // Field widths
    localparam int CODE_W = 5;
    localparam int IDX_W  = 6;
    localparam int DUR_W  = 10;
    localparam int ADDR_W = 8;

    // Command action codes
    localparam logic ACT_ENABLE = 1'b0;
    localparam logic ACT_SEND   = 1'b1;

    // Configuration register indexes
    localparam logic CFG_BIT_PERIOD = 1'b0;
    localparam logic CFG_DEV_ADDR   = 1'b1;

    // Configuration reset values
    localparam logic [DUR_W-1:0]  RESET_BIT_PERIOD = 10'd20;
    localparam logic [ADDR_W-1:0] RESET_DEV_ADDR   = 8'd114;

    // Segment timing
    localparam logic [DUR_W-1:0] ENABLE_HIGH_US = 10'd100;
    localparam logic [DUR_W-1:0] ENABLE_LOW_US  = 10'd300;
    localparam logic [DUR_W-1:0] EDGE_US        = 10'd5;
    localparam logic [DUR_W-1:0] HOLD_US        = 10'd0;

    // Run layout: enable run is 3 segments, send run is 2 x 18 + 1
    localparam logic [IDX_W-1:0] LAST_IDX_ENABLE = 6'd2;
    localparam logic [IDX_W-1:0] LAST_IDX_SEND   = 6'd36;
    localparam logic [IDX_W-1:0] BYTE_SEGS       = 6'd18;
    localparam logic [4:0]       BYTE_LAST_POS   = 5'd17;
    localparam logic [2:0]       BYTE_MSB        = 3'd7;

    // Classified command, front to back
    typedef struct packed {
        logic              is_send;
        logic [IDX_W-1:0]  last_idx;
        logic [CODE_W-1:0] code;
    } t_cmd;

    // One line segment, back to output queue
    typedef struct packed {
        logic              level;
        logic [DUR_W-1:0]  dur;
        logic              last;
        logic [CODE_W-1:0] code;
    } t_seg;

endpackage

`default_nettype wire

>>> hdl/esc_queue.sv
// ----------------------------------------------------------------------------
// esc_queue
// Two-entry register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wptr <= !r_wptr;
            end
            if (pop_ok) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

>>> hdl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Accepts command requests, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic                       i_action,
    input  wire logic [esc_pkg::CODE_W-1:0] i_value_code,
    input  wire logic                       i_cmd_pop,
    output logic                            o_full,
    output logic                            o_cmd_valid,
    output esc_pkg::t_cmd                   o_cmd
);

    esc_pkg::t_cmd                cmd_in;
    logic [$bits(esc_pkg::t_cmd)-1:0] cmd_out;
    logic                         cmd_empty;

    // classify: run length follows from the action
    always_comb begin
        cmd_in.is_send  = (i_action == esc_pkg::ACT_SEND);
        cmd_in.last_idx = (i_action == esc_pkg::ACT_SEND) ? esc_pkg::LAST_IDX_SEND
                                                           : esc_pkg::LAST_IDX_ENABLE;
        cmd_in.code     = i_value_code;
    end

    esc_queue #(
        .WIDTH ($bits(esc_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (cmd_in),
        .i_pop   (i_cmd_pop),
        .o_rdata (cmd_out),
        .o_full  (o_full),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;
    assign o_cmd       = esc_pkg::t_cmd'(cmd_out);

endmodule

`default_nettype wire

>>> hdl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Segment sequencer: walks the command at the queue head, one segment a cycle while the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_back #(
    parameter int DURATION_WIDTH = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [esc_pkg::DUR_W-1:0]  i_bit_period,
    input  wire logic [esc_pkg::ADDR_W-1:0] i_dev_addr,
    input  wire logic                       i_cmd_valid,
    input  wire esc_pkg::t_cmd              i_cmd,
    input  wire logic                       i_outq_full,
    output logic                            o_cmd_pop,
    output logic                            o_seg_valid,
    output esc_pkg::t_seg                   o_seg
);

    localparam logic [31:0] DUR_MAX = 32'((64'd1 << DURATION_WIDTH) - 64'd1);

    logic [esc_pkg::IDX_W-1:0]  r_idx;
    logic [esc_pkg::CODE_W-1:0] r_code;

    logic [11:0]                p3;
    logic [esc_pkg::DUR_W-1:0]  quarter;
    logic [esc_pkg::DUR_W-1:0]  three_q;
    logic                       second;
    logic [4:0]                 pos;
    logic [4:0]                 k;
    logic [esc_pkg::ADDR_W-1:0] byte_v;
    logic                       bit_v;
    logic                       level;
    logic [esc_pkg::DUR_W-1:0]  dur_raw;
    logic                       seg_last;
    logic                       go;

    // bit timing: quarter and three quarters, never below 1 us
    always_comb begin
        p3      = {2'b00, i_bit_period} + {1'b0, i_bit_period, 1'b0};
        quarter = {2'b00, i_bit_period[9:2]};
        three_q = p3[11:2];
        if (quarter == '0) begin
            quarter = 10'd1;
        end
        if (three_q == '0) begin
            three_q = 10'd1;
        end
    end

    // segment decode from the index
    always_comb begin
        second   = (r_idx >= esc_pkg::BYTE_SEGS);
        pos      = second ? 5'(r_idx - esc_pkg::BYTE_SEGS) : 5'(r_idx);
        k        = pos - 5'd1;
        byte_v   = second ? {3'b000, i_cmd.code} : i_dev_addr;
        bit_v    = byte_v[esc_pkg::BYTE_MSB - k[3:1]];
        seg_last = (r_idx == i_cmd.last_idx);
        level    = 1'b1;
        dur_raw  = esc_pkg::HOLD_US;
        if (seg_last) begin
            level   = 1'b1;
            dur_raw = esc_pkg::HOLD_US;
        end else if (!i_cmd.is_send) begin
            if (r_idx == '0) begin
                level   = 1'b1;
                dur_raw = esc_pkg::ENABLE_HIGH_US;
            end else begin
                level   = 1'b0;
                dur_raw = esc_pkg::ENABLE_LOW_US;
            end
        end else if (pos == '0) begin
            level   = 1'b1;
            dur_raw = esc_pkg::EDGE_US;
        end else if (pos == esc_pkg::BYTE_LAST_POS) begin
            level   = 1'b0;
            dur_raw = esc_pkg::EDGE_US;
        end else begin
            // low half then high half; a 1 bit has the short low half
            level   = k[0];
            dur_raw = (bit_v ^ k[0]) ? quarter : three_q;
        end
    end

    // output segment with duration limit
    always_comb begin
        o_seg.level = level;
        o_seg.dur   = ({22'd0, dur_raw} > DUR_MAX) ? DUR_MAX[9:0] : dur_raw;
        o_seg.last  = seg_last;
        o_seg.code  = i_cmd.is_send ? i_cmd.code : r_code;
    end

    assign go          = i_cmd_valid && !i_outq_full;
    assign o_seg_valid = go;
    assign o_cmd_pop   = go && seg_last;

    // segment counter and stored code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_code <= '0;
        end else if (go) begin
            if (seg_last) begin
                r_idx <= '0;
                if (i_cmd.is_send) begin
                    r_code <= i_cmd.code;
                end
            end else begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/easyscale_pulse_width_transmitter.sv
// A command request's first segment reaches the result ports through the
// command queue and then the result queue, and can be popped from there.
// The segment sequencer gives one segment per cycle while the result queue
// has room; an enable command expands to 3 segments, a send command to 37.
// Two command requests and two segments can be buffered.
// Reset clears both queues, bit period to 20, address to 114, stored code to 0.
// ----------------------------------------------------------------------------
// easyscale_pulse_width_transmitter
// Expands commands into single-wire segments (level, duration in us).
// ----------------------------------------------------------------------------
`default_nettype none

module easyscale_pulse_width_transmitter #(
    parameter int DURATION_WIDTH = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command side
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       i_action,
    input  wire logic [esc_pkg::CODE_W-1:0] i_value_code,
    // segment side
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_pin_level,
    output logic [esc_pkg::DUR_W-1:0]       o_duration_us,
    output logic                            o_last,
    output logic [esc_pkg::CODE_W-1:0]      o_stored_code,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [esc_pkg::DUR_W-1:0]  i_cfg_data
);

    logic [esc_pkg::DUR_W-1:0]  r_bit_period;
    logic [esc_pkg::ADDR_W-1:0] r_dev_addr;

    logic                       cmd_valid;
    esc_pkg::t_cmd              cmd;
    logic                       cmd_pop;
    logic                       seg_valid;
    esc_pkg::t_seg              seg;
    logic                       outq_full;
    logic [$bits(esc_pkg::t_seg)-1:0] outq_data;
    esc_pkg::t_seg              head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= esc_pkg::RESET_BIT_PERIOD;
            r_dev_addr   <= esc_pkg::RESET_DEV_ADDR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                esc_pkg::CFG_BIT_PERIOD: r_bit_period <= i_cfg_data;
                esc_pkg::CFG_DEV_ADDR:   r_dev_addr   <= i_cfg_data[esc_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    esc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_action     (i_action),
        .i_value_code (i_value_code),
        .i_cmd_pop    (cmd_pop),
        .o_full       (full),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    esc_back #(
        .DURATION_WIDTH (DURATION_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_period (r_bit_period),
        .i_dev_addr   (r_dev_addr),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .i_outq_full  (outq_full),
        .o_cmd_pop    (cmd_pop),
        .o_seg_valid  (seg_valid),
        .o_seg        (seg)
    );

    // result queue
    esc_queue #(
        .WIDTH ($bits(esc_pkg::t_seg))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (seg_valid),
        .i_wdata (seg),
        .i_pop   (pop),
        .o_rdata (outq_data),
        .o_full  (outq_full),
        .o_empty (empty)
    );

    assign head          = esc_pkg::t_seg'(outq_data);
    assign o_pin_level   = head.level;
    assign o_duration_us = head.dur;
    assign o_last        = head.last;
    assign o_stored_code = head.code;

    // sequencer never writes into a full result queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seg_valid |-> !outq_full)
        else $error("segment written into full result queue");

    // a command leaves the queue only with its last segment
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> (seg_valid && seg.last))
        else $error("command dropped without its last segment");

    // zero duration marks the final hold and nothing else
    a_hold_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_duration_us == '0)) |-> (o_last && o_pin_level))
        else $error("zero duration on a segment that is not the final hold");

    // final segment is always a held high
    a_last_is_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_pin_level && (o_duration_us == '0)))
        else $error("last segment is not a held high");

endmodule

`default_nettype wire

>>> tb/easyscale_segment_checker.sv
// ----------------------------------------------------------------------------
// easyscale_segment_checker
// Watches the command, segment and configuration ports of the single-wire
// pulse width transmitter. Every accepted command is expanded into the line
// segments it must produce. Each popped segment is compared field by field
// with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module easyscale_segment_checker
    import esc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command side
    input  wire logic              i_push,
    input  wire logic              i_full,
    input  wire logic              i_action,
    input  wire logic [CODE_W-1:0] i_value_code,
    // segment side
    input  wire logic              i_empty,
    input  wire logic              i_pop,
    input  wire logic              i_pin_level,
    input  wire logic [DUR_W-1:0]  i_duration_us,
    input  wire logic              i_last,
    input  wire logic [CODE_W-1:0] i_stored_code,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [DUR_W-1:0]  i_cfg_data,
    // status for the testbench top
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_cmd_count,
    output int                     o_send_count,
    output int                     o_seg_count
);

    localparam int MAX_REPORTS = 10;

    // Local copy of the transmitter state
    logic [DUR_W-1:0]  bit_period;
    logic [ADDR_W-1:0] dev_addr;
    logic [CODE_W-1:0] code_held;

    // Segments still owed by the block, oldest first
    t_seg segs_due[$];
    t_seg got_seg;
    t_seg want_seg;

    // Append one segment; it carries the code held at that point
    task automatic add_seg(input logic level, input logic [DUR_W-1:0] dur,
                           input logic last);
        segs_due.push_back('{level, dur, last, code_held});
    endtask

    // One byte on the wire: start edge, eight bits MSB first, stop edge
    task automatic add_byte(input logic [7:0] value, input logic [DUR_W-1:0] quarter,
                            input logic [DUR_W-1:0] three_q);
        add_seg(1'b1, EDGE_US, 1'b0);
        for (int b = 7; b >= 0; b--) begin
            // a 1 is a short low then a long high, a 0 the reverse
            add_seg(1'b0, value[b] ? quarter : three_q, 1'b0);
            add_seg(1'b1, value[b] ? three_q : quarter, 1'b0);
        end
        add_seg(1'b0, EDGE_US, 1'b0);
    endtask

    // Expand one command request into its run of segments
    task automatic expand_command(input logic act, input logic [CODE_W-1:0] code);
        int q_us;
        int tq_us;
        logic [7:0] data_byte;
        if (act == ACT_ENABLE) begin
            add_seg(1'b1, ENABLE_HIGH_US, 1'b0);
            add_seg(1'b0, ENABLE_LOW_US, 1'b0);
            add_seg(1'b1, HOLD_US, 1'b1);
        end else begin
            q_us  = int'(bit_period) / 4;
            tq_us = (3 * int'(bit_period)) / 4;
            // a zero width would read as hold, so short periods get 1 us
            if (q_us == 0) q_us = 1;
            if (tq_us == 0) tq_us = 1;
            code_held = code;
            data_byte = {3'b000, code};
            add_byte(dev_addr, DUR_W'(q_us), DUR_W'(tq_us));
            add_byte(data_byte, DUR_W'(q_us), DUR_W'(tq_us));
            add_seg(1'b1, HOLD_US, 1'b1);
        end
    endtask

    // Sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            segs_due.delete();
            bit_period   = RESET_BIT_PERIOD;
            dev_addr     = RESET_DEV_ADDR;
            code_held    = '0;
            o_fail_count = 0;
            o_cmd_count  = 0;
            o_send_count = 0;
            o_seg_count  = 0;
        end else begin
            // segment leaving the block
            if (i_pop && !i_empty) begin
                got_seg = '{i_pin_level, i_duration_us, i_last, i_stored_code};
                if (segs_due.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $display("ERROR: stray segment: level %0b dur %0d last %0b code %0d",
                                 got_seg.level, got_seg.dur, got_seg.last, got_seg.code);
                    o_fail_count++;
                end else begin
                    want_seg = segs_due.pop_front();
                    o_seg_count++;
                    if (got_seg !== want_seg) begin
                        if (o_fail_count < MAX_REPORTS) begin
                            $display("ERROR: seg %0d: want level %0b dur %0d last %0b code %0d",
                                     o_seg_count, want_seg.level, want_seg.dur,
                                     want_seg.last, want_seg.code);
                            $display("       got level %0b dur %0d last %0b code %0d",
                                     got_seg.level, got_seg.dur, got_seg.last,
                                     got_seg.code);
                        end
                        o_fail_count++;
                    end
                end
            end
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BIT_PERIOD)
                    bit_period = i_cfg_data;
                else
                    dev_addr = i_cfg_data[ADDR_W-1:0];
            end
            // command request entering the block
            if (i_push && !i_full) begin
                o_cmd_count++;
                if (i_action == ACT_SEND) o_send_count++;
                expand_command(i_action, i_value_code);
            end
        end
        o_pending = segs_due.size();
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives enable and send command requests into the pulse width transmitter
// under bursty input and a stalling output, changes the bit period and the
// device address between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import esc_pkg::*;

    localparam int  PHASES      = 5;
    localparam int  PHASE_ITEMS = 52;
    localparam int  IDLE_SETTLE = 8;
    localparam int  CYCLE_LIMIT = 2000000;

    typedef enum logic [1:0] {POP_FREE, POP_MOSTLY, POP_SPARSE, POP_BURSTY} t_pop_mode;

    // Block inputs, known from time zero
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              push         = 1'b0;
    logic              i_action     = ACT_ENABLE;
    logic [CODE_W-1:0] i_value_code = '0;
    logic              pop          = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic              i_cfg_idx    = CFG_BIT_PERIOD;
    logic [DUR_W-1:0]  i_cfg_data   = '0;

    // Block outputs
    logic              full;
    logic              empty;
    logic              o_pin_level;
    logic [DUR_W-1:0]  o_duration_us;
    logic              o_last;
    logic [CODE_W-1:0] o_stored_code;

    // Checker status
    int fail_count;
    int pending;
    int cmd_count;
    int send_count;
    int seg_count;

    int        cycles     = 0;
    int        n_settings = 0;
    t_pop_mode pop_mode   = POP_FREE;
    int        mode_left  = 0;
    int        stall_left = 0;

    easyscale_pulse_width_transmitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_value_code  (i_value_code),
        .empty         (empty),
        .pop           (pop),
        .o_pin_level   (o_pin_level),
        .o_duration_us (o_duration_us),
        .o_last        (o_last),
        .o_stored_code (o_stored_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    easyscale_segment_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_action      (i_action),
        .i_value_code  (i_value_code),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_pin_level   (o_pin_level),
        .i_duration_us (o_duration_us),
        .i_last        (o_last),
        .i_stored_code (o_stored_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_cmd_count   (cmd_count),
        .o_send_count  (send_count),
        .o_seg_count   (seg_count)
    );

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Segment receiver: stall pattern switches mode every so often
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                pop_mode  <= t_pop_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(50, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (pop_mode)
                POP_FREE:   pop <= 1'b1;
                POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
                POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                default: begin
                    // long stalls now and then
                    if (stall_left != 0) begin
                        pop        <= 1'b0;
                        stall_left <= stall_left - 1;
                    end else begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 30);
                    end
                end
            endcase
        end
    end

    // Present one command request and wait for it to be taken;
    // push stays high when another request follows at once
    task automatic push_command(input logic act, input logic [CODE_W-1:0] code,
                                input bit hold);
        push         <= 1'b1;
        i_action     <= act;
        i_value_code <= code;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (!hold) push <= 1'b0;
    endtask

    // Wait until every due segment has come out, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Write both registers; only called while the block is idle
    task automatic set_config(input logic [DUR_W-1:0] period, input logic [ADDR_W-1:0] addr);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BIT_PERIOD;
        i_cfg_data <= period;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DEV_ADDR;
        i_cfg_data <= DUR_W'(addr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // Stimulus and verdict
    initial begin
        logic              act;
        logic [CODE_W-1:0] code;
        logic [DUR_W-1:0]  period;
        int                burst_left;
        int                burst_max;
        int                gap_max;
        bit                end_burst;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: enable leaves the stored code alone
        push_command(ACT_ENABLE, 5'h1F, 1'b1);
        push_command(ACT_SEND,   5'h00, 1'b1);
        push_command(ACT_SEND,   5'h1F, 1'b1);
        push_command(ACT_ENABLE, 5'h00, 1'b1);
        push_command(ACT_SEND,   5'h15, 1'b0);
        wait_idle();
        // Longest period, all-ones address
        set_config(10'd1023, 8'hFF);
        push_command(ACT_SEND,   5'h1F, 1'b1);
        push_command(ACT_SEND,   5'h00, 1'b1);
        push_command(ACT_ENABLE, 5'h07, 1'b0);
        wait_idle();
        // Zero period: both halves raised to 1 us
        set_config(10'd0, 8'h00);
        push_command(ACT_SEND,   5'h0A, 1'b1);
        push_command(ACT_SEND,   5'h1F, 1'b1);
        push_command(ACT_ENABLE, 5'h1F, 1'b0);
        wait_idle();
        // Periods just below and at the quarter limit
        set_config(10'd3, 8'hAA);
        push_command(ACT_SEND, 5'h15, 1'b0);
        wait_idle();
        set_config(10'd4, 8'h55);
        push_command(ACT_SEND,   5'h0A, 1'b1);
        push_command(ACT_ENABLE, 5'h00, 1'b0);
        wait_idle();
        set_config(10'd1, 8'h80);
        push_command(ACT_SEND, 5'h01, 1'b1);
        push_command(ACT_SEND, 5'h10, 1'b0);
        wait_idle();
        set_config(10'd2, 8'h01);
        push_command(ACT_SEND, 5'h1F, 1'b0);
        wait_idle();

        // Random phases, each under its own settings and idle pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       period = DUR_W'($urandom_range(0, 3));
                1:       period = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd4;
                default: period = DUR_W'($urandom_range(4, 1023));
            endcase
            set_config(period, ADDR_W'($urandom_range(0, 255)));
            // first phase allows bursts up to the whole phase length
            burst_max  = (ph == 0) ? PHASE_ITEMS : $urandom_range(2, 10);
            gap_max    = $urandom_range(5, 60);
            burst_left = $urandom_range(1, burst_max);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                act  = ($urandom_range(0, 9) < 7) ? ACT_SEND : ACT_ENABLE;
                code = CODE_W'($urandom_range(0, 31));
                end_burst = (burst_left <= 1) || (k == PHASE_ITEMS / 2) ||
                            (k == PHASE_ITEMS - 1);
                push_command(act, code, !end_burst);
                if (end_burst) begin
                    burst_left = $urandom_range(1, burst_max);
                    // midway the sender holds off until the block has drained
                    if (k == PHASE_ITEMS / 2)
                        wait_idle();
                    else if (k != PHASE_ITEMS - 1)
                        repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                end else begin
                    burst_left--;
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d commands (%0d send, %0d enable), %0d segments checked,",
                 cmd_count, send_count, cmd_count - send_count, seg_count);
        $display("over %0d bit period and address settings including the extremes.",
                 n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
